// ----- hw/rtl/msc_pkg.sv -----
// Package with shared types and codes of the MIPS subset step core.
`timescale 1ns / 1ps
package msc_pkg;
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_EXEC = 2'd1;
    localparam logic [1:0] CMD_RDMEM = 2'd2;
    localparam logic [1:0] CMD_RDREG = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_FETCH = 3'd1;
    localparam logic [2:0] ST_BAD_OP = 3'd2;
    localparam logic [2:0] ST_BAD_FN = 3'd3;
    localparam logic [2:0] ST_BAD_ADDR = 3'd4;
    localparam logic [2:0] ST_HALTED = 3'd5;

    localparam logic [5:0] OP_RTYPE = 6'd0;
    localparam logic [5:0] OP_J = 6'd2;
    localparam logic [5:0] OP_BEQ = 6'd4;
    localparam logic [5:0] OP_ADDI = 6'd8;
    localparam logic [5:0] OP_ADDIU = 6'd9;
    localparam logic [5:0] OP_SLTI = 6'd10;
    localparam logic [5:0] OP_SLTIU = 6'd11;
    localparam logic [5:0] OP_LUI = 6'd15;
    localparam logic [5:0] OP_LW = 6'd35;
    localparam logic [5:0] OP_SW = 6'd43;

    localparam logic [5:0] FN_SHL16 = 6'd6;
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR = 6'd37;
    localparam logic [5:0] FN_NOT = 6'd39;
    localparam logic [5:0] FN_SLT = 6'd42;
    localparam logic [5:0] FN_SLTU = 6'd43;

    localparam logic [31:0] ALIAS_PC = 32'h0000_4000;
    localparam logic [31:0] SP_RESET = 32'h0000_FFFC;
    localparam logic [31:0] GP_RESET = 32'h0000_C000;

    typedef struct packed {
        logic [2:0] status;
        logic halted;
        logic [31:0] pc;
        logic [31:0] read_data;
        logic reg_written;
        logic [4:0] reg_index;
        logic [31:0] reg_value;
        logic mem_written;
        logic [15:0] mem_address;
        logic [31:0] mem_value;
    } msc_result_t;
endpackage

// ----- hw/rtl/msc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module msc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic aclk,
    input  logic wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- hw/rtl/msc_alu.sv -----
// Instruction decode and ALU: results, next pc and fault status of one instruction.
`timescale 1ns / 1ps
module msc_alu (
    input  logic [31:0] ins,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] pc,
    output logic [2:0] status,
    output logic [31:0] res,
    output logic wr,
    output logic [4:0] dest,
    output logic is_lw,
    output logic is_sw,
    output logic [31:0] addr,
    output logic [31:0] next_pc
);
    import msc_pkg::*;
    logic [5:0] op;
    logic [5:0] fn;
    logic [31:0] imm;
    logic [31:0] pc4;

    always_comb begin
        op = ins[31:26];
        fn = ins[5:0];
        imm = {{16{ins[15]}}, ins[15:0]};
        pc4 = pc + 32'd4;
        status = ST_OK;
        res = '0;
        wr = 1'b0;
        dest = ins[20:16];
        is_lw = 1'b0;
        is_sw = 1'b0;
        addr = a + imm;
        next_pc = pc4;
        case (op)
            OP_RTYPE: begin
                wr = 1'b1;
                dest = ins[15:11];
                case (fn)
                    FN_SHL16: res = {b[15:0], 16'h0000};
                    FN_ADD: res = a + b;
                    FN_SUB: res = a - b;
                    FN_AND: res = a & b;
                    FN_OR: res = a | b;
                    FN_NOT: res = ~a;
                    FN_SLT: res = {31'd0, $signed(a) < $signed(b)};
                    FN_SLTU: res = {31'd0, a < b};
                    default: begin
                        status = ST_BAD_FN;
                        wr = 1'b0;
                    end
                endcase
            end
            OP_J: next_pc = {pc4[31:28], ins[25:0], 2'b00};
            OP_BEQ: if (a == b) next_pc = pc4 + {imm[29:0], 2'b00};
            OP_ADDI, OP_ADDIU: begin
                res = a + imm;
                wr = 1'b1;
            end
            OP_SLTI: begin
                res = {31'd0, $signed(a) < $signed(imm)};
                wr = 1'b1;
            end
            OP_SLTIU: begin
                res = {31'd0, a < imm};
                wr = 1'b1;
            end
            OP_LUI: begin
                res = {ins[15:0], 16'h0000};
                wr = 1'b1;
            end
            OP_LW: is_lw = 1'b1;
            OP_SW: is_sw = 1'b1;
            default: status = ST_BAD_OP;
        endcase
    end
endmodule

// ----- hw/rtl/mips_subset_single_cycle_step_core.sv -----
// Top level of the MIPS subset step core: command sequencer over memory and register file.
`timescale 1ns / 1ps
// Usage
// The slave channel carries one command per transfer: load a memory word,
// execute one instruction, read a memory word or read a register. Each
// command yields exactly one result transfer on the master channel with the
// status, halt flag, program counter and write-back report.
// A load, and an execute refused because the core is halted or the fetch
// is bad, register their result at the accepting edge; reads pass through
// the read-wait state. An execute issues the instruction fetch at the
// accepting edge and the register-file read in the fetch state, waits in
// the register-read state, and the ALU forms the result together with any
// store in the execute state. A load word adds the load state for its data read.
// One command is in flight at a time; the next is taken in the cycle in
// which the waiting result is taken, so loads can follow back to back.
// Reset clears pc and the halt flag and starts a clearing pass that writes
// zero to every memory word and the reset values into the register file;
// no command is taken during the pass.
// When the receiver stalls, the result holds in the output register and no
// further command is taken until that result has been taken.
module mips_subset_single_cycle_step_core #(
    parameter int MEM_WORDS = 16384,
    parameter int CODE_BASE_WORD = 4096
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // tdata: command[1:0], target_index[15:2], write_data[47:16]
    input  logic [47:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // tdata: status[2:0], halted[3], program_counter[35:4], read_data[67:36],
    // reg_written[68], reg_index[73:69], reg_value[105:74], mem_written[106],
    // mem_address[122:107], mem_value[154:123], zero fill to 160
    output logic [159:0] m_tdata
);
    import msc_pkg::*;
    localparam int AW = $clog2(MEM_WORDS);

    typedef enum logic [6:0] {
        S_CLR = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_REGRD = 7'b0001000,
        S_EXEC = 7'b0010000,
        S_LOAD = 7'b0100000,
        S_RDWAIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [AW:0] clr_reg, clr_next;
    logic [31:0] pc_reg, pc_next;
    logic halt_reg, halt_next;
    logic [1:0] cmd_reg, cmd_next;
    logic [13:0] tix_reg, tix_next;
    logic [31:0] ins_reg, ins_next;
    logic [4:0] dest_reg, dest_next;
    logic [31:0] npc_reg, npc_next;
    logic out_v_reg, out_v_next;
    msc_result_t out_reg, out_next;

    logic mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [31:0] mem_wd, mem_rd;
    logic rf_we;
    logic [4:0] rf_wa, rf_ra_a, rf_ra_b;
    logic [31:0] rf_wd, rf_rd_a, rf_rd_b;

    logic [2:0] alu_status;
    logic [31:0] alu_res, alu_addr, alu_npc;
    logic alu_wr, alu_lw, alu_sw;
    logic [4:0] alu_dest;

    logic [1:0] in_cmd;
    logic [13:0] in_tix;
    logic [31:0] in_wd;
    logic [31:0] fpc;
    logic [31:0] fidx;
    logic tix_ok;
    logic [31:0] waddr_w;
    logic addr_ok;

    assign in_cmd = s_tdata[1:0];
    assign in_tix = s_tdata[15:2];
    assign in_wd = s_tdata[47:16];
    assign s_tready = (state_reg == S_IDLE) && (!out_v_reg || m_tready);
    assign m_tvalid = out_v_reg;
    assign m_tdata = {5'd0, out_reg.mem_value, out_reg.mem_address, out_reg.mem_written,
                      out_reg.reg_value, out_reg.reg_index, out_reg.reg_written,
                      out_reg.read_data, out_reg.pc, out_reg.halted, out_reg.status};

    // Start address alias folds 0x4000 back to zero before fetching.
    assign fpc = (pc_reg == ALIAS_PC) ? 32'd0 : pc_reg;
    assign fidx = {2'b00, fpc[31:2]} + 32'(CODE_BASE_WORD);
    assign tix_ok = 32'(tix_reg) < 32'(MEM_WORDS);
    assign waddr_w = {2'b00, alu_addr[31:2]};
    assign addr_ok = (alu_addr[1:0] == 2'b00) && (waddr_w < 32'(MEM_WORDS));

    msc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
        .aclk(aclk), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
        .rd_addr(mem_ra), .rd_data(mem_rd)
    );
    msc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .aclk(aclk), .wr_en(rf_we), .wr_addr(rf_wa), .wr_data(rf_wd),
        .rd_addr(rf_ra_a), .rd_data(rf_rd_a)
    );
    msc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .aclk(aclk), .wr_en(rf_we), .wr_addr(rf_wa), .wr_data(rf_wd),
        .rd_addr(rf_ra_b), .rd_data(rf_rd_b)
    );

    msc_alu u_alu (
        .ins(ins_reg), .a(rf_rd_a), .b(rf_rd_b), .pc(fpc),
        .status(alu_status), .res(alu_res), .wr(alu_wr), .dest(alu_dest),
        .is_lw(alu_lw), .is_sw(alu_sw), .addr(alu_addr), .next_pc(alu_npc)
    );

    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        pc_next = pc_reg;
        halt_next = halt_reg;
        cmd_next = cmd_reg;
        tix_next = tix_reg;
        ins_next = ins_reg;
        dest_next = dest_reg;
        npc_next = npc_reg;
        out_v_next = out_v_reg;
        out_next = out_reg;
        mem_we = 1'b0;
        mem_wa = AW'(tix_reg);
        mem_wd = in_wd;
        mem_ra = AW'(tix_reg);
        rf_we = 1'b0;
        rf_wa = alu_dest;
        rf_wd = alu_res;
        rf_ra_a = ins_reg[25:21];
        rf_ra_b = ins_reg[20:16];

        if (out_v_reg && m_tready) begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            S_CLR: begin
                mem_we = 1'b1;
                mem_wa = clr_reg[AW-1:0];
                mem_wd = '0;
                if (clr_reg < (AW+1)'(32)) begin
                    rf_we = 1'b1;
                    rf_wa = clr_reg[4:0];
                    rf_wd = (clr_reg == (AW+1)'(29)) ? SP_RESET :
                            (clr_reg == (AW+1)'(28)) ? GP_RESET : 32'd0;
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(MEM_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd_next = in_cmd;
                    tix_next = in_tix;
                    out_next = '0;
                    out_next.halted = halt_reg;
                    out_next.pc = pc_reg;
                    case (in_cmd)
                        CMD_LOAD: begin
                            if (32'(in_tix) < 32'(MEM_WORDS)) begin
                                mem_we = 1'b1;
                                mem_wa = AW'(in_tix);
                            end else begin
                                out_next.status = ST_BAD_ADDR;
                            end
                            out_v_next = 1'b1;
                        end
                        CMD_EXEC: begin
                            if (halt_reg) begin
                                out_next.status = ST_HALTED;
                                out_v_next = 1'b1;
                            end else if (fpc[1:0] != 2'b00 ||
                                         fidx >= 32'(MEM_WORDS)) begin
                                out_next.status = ST_BAD_FETCH;
                                halt_next = 1'b1;
                                out_next.halted = 1'b1;
                                pc_next = fpc;
                                out_next.pc = fpc;
                                out_v_next = 1'b1;
                            end else begin
                                mem_ra = fidx[AW-1:0];
                                pc_next = fpc;
                                out_next.pc = fpc;
                                state_next = S_FETCH;
                            end
                        end
                        CMD_RDMEM: begin
                            mem_ra = AW'(in_tix);
                            state_next = S_RDWAIT;
                        end
                        default: begin
                            rf_ra_a = in_tix[4:0];
                            state_next = S_RDWAIT;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                ins_next = mem_rd;
                rf_ra_a = mem_rd[25:21];
                rf_ra_b = mem_rd[20:16];
                state_next = S_REGRD;
            end
            S_REGRD: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (alu_status != ST_OK) begin
                    out_next.status = alu_status;
                    halt_next = 1'b1;
                    out_next.halted = 1'b1;
                    out_v_next = 1'b1;
                    state_next = S_IDLE;
                end else if ((alu_lw || alu_sw) && !addr_ok) begin
                    out_next.status = ST_BAD_ADDR;
                    halt_next = 1'b1;
                    out_next.halted = 1'b1;
                    out_v_next = 1'b1;
                    state_next = S_IDLE;
                end else if (alu_lw) begin
                    mem_ra = alu_addr[AW+1:2];
                    dest_next = alu_dest;
                    npc_next = alu_npc;
                    state_next = S_LOAD;
                end else begin
                    if (alu_sw) begin
                        mem_we = 1'b1;
                        mem_wa = alu_addr[AW+1:2];
                        mem_wd = rf_rd_b;
                        out_next.mem_written = 1'b1;
                        out_next.mem_address = alu_addr[15:0];
                        out_next.mem_value = rf_rd_b;
                    end
                    if (alu_wr && alu_dest != 5'd0) begin
                        rf_we = 1'b1;
                        out_next.reg_written = 1'b1;
                        out_next.reg_index = alu_dest;
                        out_next.reg_value = alu_res;
                    end
                    pc_next = alu_npc;
                    out_next.pc = alu_npc;
                    out_v_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LOAD: begin
                if (dest_reg != 5'd0) begin
                    rf_we = 1'b1;
                    rf_wa = dest_reg;
                    rf_wd = mem_rd;
                    out_next.reg_written = 1'b1;
                    out_next.reg_index = dest_reg;
                    out_next.reg_value = mem_rd;
                end
                pc_next = npc_reg;
                out_next.pc = npc_reg;
                out_v_next = 1'b1;
                state_next = S_IDLE;
            end
            S_RDWAIT: begin
                if (cmd_reg == CMD_RDMEM) begin
                    if (tix_ok) out_next.read_data = mem_rd;
                    else out_next.status = ST_BAD_ADDR;
                end else begin
                    if (tix_reg < 14'd32) out_next.read_data = rf_rd_a;
                    else out_next.status = ST_BAD_ADDR;
                end
                out_v_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            pc_reg <= '0;
            halt_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            pc_reg <= pc_next;
            halt_reg <= halt_next;
            out_v_reg <= out_v_next;
        end
        cmd_reg <= cmd_next;
        tix_reg <= tix_next;
        ins_reg <= ins_next;
        dest_reg <= dest_next;
        npc_reg <= npc_next;
        out_reg <= out_next;
    end
endmodule

// ----- hw/rtl/msc_checker.sv -----
// Port-level checker for the MIPS subset step core, bound to the top level.
`timescale 1ns / 1ps
module msc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic [47:0] s_tdata,
    input logic m_tvalid,
    input logic m_tready,
    input logic [159:0] m_tdata
);
    import msc_pkg::*;

    // A stalled result holds still.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // A waiting command transfer holds still until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("command changed while waiting");

    // A taken halted result is not directly followed by a valid result that reports running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[3] |=> !(m_tvalid && !m_tdata[3]))
        else $error("halt flag cleared");

    // Status never exceeds the defined codes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= ST_HALTED)
        else $error("bad status code");

    // No command is taken while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("command taken over pending result");
endmodule

bind mips_subset_single_cycle_step_core msc_checker u_msc_checker (.*);
